// ===== hw/rtl/rgbcf_pkg.sv =====
// Types and constants shared by the RGB 3x3 convolution filter.
package rgbcf_pkg;

  // Input beat: one pixel or a flush item
  typedef struct packed {
    logic       req_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  // Output beat: one filtered pixel
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } pix_out_t;

  // Kernel selection codes; unlisted codes filter as box blur
  typedef enum logic [2:0] {
    KM_BOX     = 3'd0,
    KM_GAUSS   = 3'd1,
    KM_OUTLINE = 3'd2,
    KM_EMBOSS  = 3'd3,
    KM_SHARPEN = 3'd4
  } kernel_mode_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KERNEL_MODE  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  // Reciprocal of 9 in 16 fractional bits, rounded up (exact for sums below 2^12)
  localparam logic [12:0] BOX_RECIP = 13'd7282;
  localparam int          BOX_SHIFT = 16;

  // Gaussian divide by 16
  localparam int GAUSS_SHIFT = 4;

  // Clamp limit of an output color
  localparam logic [12:0] COLOR_MAX = 13'd255;

endpackage

// ===== hw/rtl/rgb_conv3x3_filter.sv =====
// Streaming 3x3 RGB convolution filter with two line stores in one memory.
// A result leaves the output register after the input beat that completes its
//   window, i.e. width+1 beats after its center pixel; end a frame with flushes.
// Throughput: one beat per unstalled cycle; set by the read-modify-write of the
//   line memory, a read and a write each cycle, forwarded on same-column reuse.
// Reset: counters, window and pipeline valids clear; line memory is not cleared.
module rgb_conv3x3_filter #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst,
  // pixel input channel
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  rgbcf_pkg::pix_in_t  pixel,
  // result output channel
  output logic              result_valid,
  input  logic              result_stall,
  output rgbcf_pkg::pix_out_t result,
  // configuration write port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import rgbcf_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = (AW + 1 > 12) ? AW + 1 : 12;
  localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);

  // configuration registers
  logic [11:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  kernel_mode;

  // stream counters
  logic [AW-1:0] in_column, in_column_next;
  logic [1:0]    in_row, in_row_next;
  logic [AW-1:0] out_column, out_column_next;
  logic [15:0]   out_row, out_row_next;

  // line memory: {upper row, lower row} per column
  logic [47:0] row_mem [MAX_WIDTH];
  logic [47:0] rdata;

  // stage 1: memory data returns, window and memory update
  logic          s1_v;
  logic [AW-1:0] s1_col;
  logic [23:0]   s1_px;
  logic          s1_res;
  logic [8:0]    s1_keep;
  logic          s1_last;
  logic          s1_fwd;
  logic [47:0]   s1_fwd_data;
  logic [47:0]   s1_rows;

  // stage 2: weighted sums from the window
  logic        s2_v;
  logic [8:0]  s2_keep;
  logic        s2_last;
  logic [23:0] win [9];

  // stage 3: scale and clamp
  logic              s3_v;
  logic              s3_last;
  logic signed [13:0] s3_sum [3];
  logic signed [13:0] sum_c [3];
  logic [7:0]         color_c [3];

  // front-end decode
  logic          en, acc;
  logic [CW-1:0] iw_ext, w_m1_wide;
  logic [AW-1:0] w_m1;
  logic [15:0]   h_m1;
  logic          primed, last_now, out_col_end, out_row_end;
  logic [8:0]    keep_now;
  logic [23:0]   px_now;

  // pipeline advances whenever the output register is free or draining
  assign en          = !result_valid || !result_stall;
  assign pixel_stall = !en;
  assign acc         = pixel_valid && en;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      kernel_mode  <= KM_BOX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[11:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_KERNEL_MODE:  kernel_mode  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // effective width minus one, clipped to the line memory
  always_comb begin
    iw_ext = CW'(image_width);
    if (iw_ext == '0) begin
      w_m1_wide = '0;
    end else if (iw_ext > MAXW_C) begin
      w_m1_wide = MAXW_C - CW'(1);
    end else begin
      w_m1_wide = iw_ext - CW'(1);
    end
    w_m1 = w_m1_wide[AW-1:0];
    h_m1 = (image_height == 16'd0) ? 16'd0 : image_height - 16'd1;
  end

  // border mask, frame end and counter advance for the incoming beat
  always_comb begin
    px_now      = pixel.req_type ? 24'd0 : {pixel.red_in, pixel.green_in, pixel.blue_in};
    primed      = (in_row >= 2'd2) || ((in_row == 2'd1) && (in_column != '0));
    out_col_end = out_column >= w_m1;
    out_row_end = out_row >= h_m1;
    last_now    = out_row_end && out_col_end;

    keep_now = 9'h1FF;
    if (out_row == 16'd0) keep_now = keep_now & ~9'h007;
    if (out_row_end)      keep_now = keep_now & ~9'h1C0;
    if (out_column == '0) keep_now = keep_now & ~9'h049;
    if (out_col_end)      keep_now = keep_now & ~9'h124;

    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;

    if (in_column >= w_m1) begin
      in_column_next = '0;
      if (in_row < 2'd2) in_row_next = in_row + 2'd1;
    end else begin
      in_column_next = in_column + AW'(1);
    end

    if (primed) begin
      if (last_now) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
      end else if (out_col_end) begin
        out_column_next = '0;
        out_row_next    = out_row + 16'd1;
      end else begin
        out_column_next = out_column + AW'(1);
      end
    end
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (acc) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // line rows seen by stage 1, forwarded when the previous beat wrote the same column
  assign s1_rows = s1_fwd ? s1_fwd_data : rdata;

  // line memory: read on accept, write back on stage 1 advance
  always_ff @(posedge clk) begin
    if (acc) begin
      rdata <= row_mem[in_column];
    end
    if (en && s1_v) begin
      row_mem[s1_col] <= {s1_rows[23:0], s1_px};
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col      <= in_column;
      s1_px       <= px_now;
      s1_res      <= primed;
      s1_keep     <= keep_now;
      s1_last     <= last_now;
      s1_fwd      <= s1_v && (s1_col == in_column);
      s1_fwd_data <= {s1_rows[23:0], s1_px};
    end
  end

  // window shift: columns move left, new column from memory and input
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) win[k] <= '0;
    end else if (en && s1_v) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]     <= win[r*3 + 1];
        win[r*3 + 1] <= win[r*3 + 2];
      end
      win[2] <= s1_rows[47:24];
      win[5] <= s1_rows[23:0];
      win[8] <= s1_px;
    end
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v && s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_keep <= s1_keep;
      s2_last <= s1_last;
    end
  end

  // weighted sum of one color over the masked window
  function automatic logic signed [13:0] kern_sum(input logic [2:0] mode,
                                                  input logic [8:0] keep,
                                                  input logic [8:0][7:0] taps);
    logic signed [13:0] m [9];
    logic signed [13:0] s;
    for (int k = 0; k < 9; k++) begin
      m[k] = keep[k] ? $signed({6'd0, taps[k]}) : 14'sd0;
    end
    case (mode)
      KM_GAUSS:
        s = m[0] + m[2] + m[6] + m[8] + ((m[1] + m[3] + m[5] + m[7]) <<< 1) + (m[4] <<< 2);
      KM_OUTLINE:
        s = (m[4] <<< 3) - m[0] - m[1] - m[2] - m[3] - m[5] - m[6] - m[7] - m[8];
      KM_EMBOSS:
        s = m[4] + m[5] + m[7] + (m[8] <<< 1) - (m[0] <<< 1) - m[1] - m[3];
      KM_SHARPEN:
        s = (m[4] <<< 2) + m[4] - m[1] - m[3] - m[5] - m[7];
      default:
        s = m[0] + m[1] + m[2] + m[3] + m[4] + m[5] + m[6] + m[7] + m[8];
    endcase
    return s;
  endfunction

  // gather each color plane of the window and sum it
  always_comb begin
    logic [8:0][7:0] plane;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 9; k++) begin
        plane[k] = win[k][(2 - c)*8 +: 8];
      end
      sum_c[c] = kern_sum(kernel_mode, s2_keep, plane);
    end
  end

  // stage 3 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_last <= s2_last;
      for (int c = 0; c < 3; c++) s3_sum[c] <= sum_c[c];
    end
  end

  // clamp negative to zero, divide for box blur and Gaussian, clamp to 255
  always_comb begin
    logic [12:0] v;
    logic [24:0] prod;
    logic [12:0] q;
    for (int c = 0; c < 3; c++) begin
      v    = s3_sum[c][13] ? 13'd0 : s3_sum[c][12:0];
      prod = 25'(v[11:0]) * 25'(BOX_RECIP);
      case (kernel_mode)
        KM_GAUSS:   q = v >> GAUSS_SHIFT;
        KM_OUTLINE: q = v;
        KM_EMBOSS:  q = v;
        KM_SHARPEN: q = v;
        default:    q = 13'(prod[24:BOX_SHIFT]);
      endcase
      color_c[c] = (q > COLOR_MAX) ? 8'd255 : q[7:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.red_out   <= color_c[0];
      result.green_out <= color_c[1];
      result.blue_out  <= color_c[2];
      result.frame_end <= s3_last;
    end
  end

`ifndef NO_ASSERTIONS
  // a frame-ending beat returns all stream counters to the frame start
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && primed && last_now) |=>
      (in_column == '0 && in_row == 2'd0 && out_column == '0 && out_row == 16'd0))
    else $error("counters not cleared after frame end");

  // the last pixel of a frame never sees taps below or right of it
  a_last_mask: assert property (@(posedge clk) disable iff (rst)
    (s2_v && s2_last) |-> (s2_keep[8:6] == 3'b000 && s2_keep[5] == 1'b0 &&
                           s2_keep[2] == 1'b0))
    else $error("frame end pixel with open bottom or right taps");

  // a primed beat leaving stage 1 becomes a stage 2 result
  a_s2_fill: assert property (@(posedge clk) disable iff (rst)
    (en && s1_v && s1_res) |=> s2_v)
    else $error("result lost between stage 1 and stage 2");

  // a read that meets a write-back to its column takes the forwarded rows
  a_forward: assert property (@(posedge clk) disable iff (rst)
    (acc && s1_v && s1_col == in_column) |=> s1_fwd)
    else $error("same-column read not forwarded");
`endif

endmodule

// ===== test/rgbcf_checker.sv =====
// Checker for the RGB 3x3 filter: watches the channels, predicts each filtered pixel, compares.
`timescale 1ns / 100ps

module rgbcf_checker #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  input  logic                pixel_stall,
  input  rgbcf_pkg::pix_in_t  pixel,
  input  logic                result_valid,
  input  logic                result_stall,
  input  rgbcf_pkg::pix_out_t result,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  open_count,
  output int                  fail_count
);

  import rgbcf_pkg::*;

  typedef logic [23:0] rgb_t;

  // Shadow copy of the filter state
  rgb_t        upper_row [MAX_WIDTH];
  rgb_t        lower_row [MAX_WIDTH];
  rgb_t        window [9];
  logic [11:0] width_reg;
  logic [15:0] height_reg;
  logic [2:0]  mode_reg;
  int unsigned in_col, in_row, out_col, out_row;

  // Filtered pixels still to come out of the block
  pix_out_t due_pixels [$];
  int       results_seen = 0;
  int       mismatches = 0;
  int       backlog = 0;

  assign open_count = backlog;
  assign fail_count = mismatches;

  // Line stores hold zero until written; only masked taps ever see that
  initial begin
    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
    mismatches++;
  endtask

  // Signed weight of window tap k, taps numbered row by row from the top left
  function automatic int tap_weight(input kernel_mode_t km, input int k);
    case (km)
      KM_GAUSS: begin
        if (k == 4) return 4;
        return (k % 2 == 1) ? 2 : 1;
      end
      KM_OUTLINE: return (k == 4) ? 8 : -1;
      KM_EMBOSS: begin
        case (k)
          0:       return -2;
          1, 3:    return -1;
          2, 6:    return 0;
          4, 5, 7: return 1;
          default: return 2;
        endcase
      end
      KM_SHARPEN: begin
        if (k == 4) return 5;
        return (k % 2 == 1) ? -1 : 0;
      end
      default: return 1;
    endcase
  endfunction

  // Weighted sum of one color over the kept taps, floored, divided for box and Gaussian, clamped
  function automatic logic [7:0] filter_color(input int shift, input logic [8:0] keep,
                                              input kernel_mode_t km);
    int sum = 0;
    int quot;
    for (int k = 0; k < 9; k++) begin
      if (keep[k]) begin
        sum += int'(window[k][shift +: 8]) * tap_weight(km, k);
      end
    end
    if (sum < 0) sum = 0;
    case (km)
      KM_BOX:   quot = sum / 9;
      KM_GAUSS: quot = sum / 16;
      default:  quot = sum;
    endcase
    if (quot > 255) quot = 255;
    return 8'(quot);
  endfunction

  // Advance the shadow state by one input beat; queue the pixel it completes
  task automatic convolve_beat(input pix_in_t beat);
    int unsigned cols, rows, col;
    rgb_t        top_px, mid_px, px;
    logic [8:0]  keep;
    kernel_mode_t km;
    bit          primed, last;
    pix_out_t    want;
    cols = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    rows = (height_reg == 0) ? 1 : height_reg;
    km = (mode_reg > KM_SHARPEN) ? KM_BOX : kernel_mode_t'(mode_reg);
    // a flush beat enters as a black pixel
    px = beat.req_type ? '0 : {beat.red_in, beat.green_in, beat.blue_in};

    // shift the line stores and the window
    col = in_col % MAX_WIDTH;
    top_px = upper_row[col];
    mid_px = lower_row[col];
    upper_row[col] = mid_px;
    lower_row[col] = px;
    for (int r = 0; r < 3; r++) begin
      window[r * 3] = window[r * 3 + 1];
      window[r * 3 + 1] = window[r * 3 + 2];
    end
    window[2] = top_px;
    window[5] = mid_px;
    window[8] = px;

    primed = in_row >= 2 || (in_row == 1 && in_col >= 1);
    if (in_col >= cols - 1) begin
      in_col = 0;
      if (in_row < 65535) in_row++;
    end else begin
      in_col++;
    end
    if (!primed) return;

    // drop taps that fall outside the image
    keep = '1;
    if (out_row == 0) keep[2:0] = '0;
    if (out_row >= rows - 1) keep[8:6] = '0;
    if (out_col == 0) begin
      keep[0] = 1'b0;
      keep[3] = 1'b0;
      keep[6] = 1'b0;
    end
    if (out_col >= cols - 1) begin
      keep[2] = 1'b0;
      keep[5] = 1'b0;
      keep[8] = 1'b0;
    end
    last = out_row >= rows - 1 && out_col >= cols - 1;

    want.red_out   = filter_color(16, keep, km);
    want.green_out = filter_color(8, keep, km);
    want.blue_out  = filter_color(0, keep, km);
    want.frame_end = last;
    due_pixels.push_back(want);

    // step the output position; the frame end restarts every counter
    if (last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else if (out_col >= cols - 1) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", field, got, want));
    end
  endtask

  task automatic check_result(input pix_out_t got);
    pix_out_t want;
    if (due_pixels.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing pending", got));
    end else begin
      want = due_pixels.pop_front();
      check_field("red", got.red_out, want.red_out);
      check_field("green", got.green_out, want.green_out);
      check_field("blue", got.blue_out, want.blue_out);
      check_field("frame_end", 8'(got.frame_end), 8'(want.frame_end));
    end
    results_seen++;
  endtask

  // Sample every channel at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      mode_reg = KM_BOX;
      foreach (window[k]) window[k] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      due_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data[11:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          CFG_KERNEL_MODE:  mode_reg = cfg_data[2:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) check_result(result);
      if (pixel_valid && !pixel_stall) convolve_beat(pixel);
    end
    backlog <= due_pixels.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the RGB 3x3 filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  import rgbcf_pkg::*;

  localparam int MAX_WIDTH = 2048;
  localparam int RANDOM_BEATS = 540;
  localparam int DRAIN_CYCLES = 8;
  localparam int RUN_LIMIT_NS = 4_000_000;

  // Input beat kinds and a mode code the package leaves unnamed
  localparam logic       REQ_PIXEL = 1'b0;
  localparam logic       REQ_FLUSH = 1'b1;
  localparam logic [2:0] MODE_UNLISTED = 3'd7;

  logic        clk;
  logic        rst = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  pix_in_t     pixel = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  pix_out_t    result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_IMAGE_WIDTH;
  logic [15:0] cfg_data = '0;
  int          open_count;
  int          fail_count;

  int gap_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int cur_cols = 1;
  int cur_rows = 1;

  rgb_conv3x3_filter #(.MAX_WIDTH(MAX_WIDTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rgbcf_checker #(.MAX_WIDTH(MAX_WIDTH)) filter_chk (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .open_count   (open_count),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #RUN_LIMIT_NS;
    $display("simulation failed");
    $finish;
  end

  // Hold the result channel off in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Color level biased toward black and full scale
  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Present one beat, maybe after an idle burst, and wait until it is taken
  task automatic send_beat(input pix_in_t beat);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    pixel <= beat;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid and wait until every filtered pixel has come out
  task automatic settle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back; unused upper data bits carry noise
  task automatic configure(input logic [11:0] cols_reg, input logic [15:0] rows_reg,
                           input logic [2:0] mode);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data <= {4'($urandom), cols_reg};
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data <= rows_reg;
    @(posedge clk);
    cfg_index <= CFG_KERNEL_MODE;
    cfg_data <= {13'($urandom), mode};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_WIDTH) ? MAX_WIDTH : cols_reg);
    cur_rows = (rows_reg == 0) ? 1 : rows_reg;
  endtask

  // One frame plus the width+1 trailing beats that push its end out
  task automatic run_frame(input int flush_pct, input bit tail_pixels);
    pix_in_t beat;
    for (int n = 0; n < cur_cols * cur_rows + cur_cols + 1; n++) begin
      if (n < cur_cols * cur_rows) begin
        beat.req_type = ($urandom_range(1, 100) <= flush_pct) ? REQ_FLUSH : REQ_PIXEL;
      end else begin
        beat.req_type = (tail_pixels && $urandom_range(0, 1) == 0) ? REQ_PIXEL : REQ_FLUSH;
      end
      beat.red_in = random_level();
      beat.green_in = random_level();
      beat.blue_in = random_level();
      send_beat(beat);
    end
  endtask

  initial begin
    pix_in_t beat;
    int      random_start;
    int      round;
    int      cols_pick;
    int      rows_pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // 3x3 outline on a checkerboard: sums overflow and go negative; a flush
    // sits on the center and colored pixels past the frame trail it
    configure(12'd3, 16'd3, KM_OUTLINE);
    for (int n = 0; n < 13; n++) begin
      beat.req_type = (n == 4) ? REQ_FLUSH : REQ_PIXEL;
      beat.red_in = (n % 2 == 0) ? 8'hFF : 8'h00;
      beat.green_in = (n % 2 == 0) ? 8'h00 : 8'hFF;
      beat.blue_in = (n < 9) ? random_level() : 8'($urandom);
      send_beat(beat);
    end
    settle();

    // zero width and height act as one, an unlisted mode as box blur
    configure(12'd0, 16'd0, MODE_UNLISTED);
    beat = '{req_type: REQ_PIXEL, red_in: 8'hFF, green_in: 8'hFF, blue_in: 8'hFF};
    send_beat(beat);
    beat.req_type = REQ_FLUSH;
    send_beat(beat);
    send_beat(beat);
    settle();

    // Random frames over every mode, small sizes, varying idle pressure
    random_start = beats_sent;
    round = 0;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      cols_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
      rows_pick = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      configure(12'(cols_pick), 16'(rows_pick),
                (round < 8) ? 3'(round) : 3'($urandom_range(0, 7)));
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 4;
        default: gap_pct = 15;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 3;
        default: stall_pct = 10;
      endcase
      repeat ($urandom_range(1, 3)) begin
        run_frame(($urandom_range(0, 2) == 0) ? 30 : $urandom_range(0, 4),
                  1'($urandom_range(0, 1)));
      end
      settle();
      round++;
    end

    // Full rate to the end: a wide short frame, then a tall one-pixel column
    gap_pct = 0;
    stall_pct = 0;
    configure(12'd40, 16'd3, KM_SHARPEN);
    run_frame(10, 1'b1);
    settle();
    configure(12'd1, 16'd40, KM_EMBOSS);
    run_frame(10, 1'b0);
    settle();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
